@@ sv/mbs_pkg.sv @@
// shared types and constants for the modbus tcp register server
package mbs_pkg;

  localparam logic [7:0]  FUNC_READ      = 8'h03;
  localparam logic [7:0]  FUNC_WRITE     = 8'h06;
  localparam logic [7:0]  FUNC_EXC_FLAG  = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_FN = 8'h01;
  localparam logic [7:0]  EXC_BAD_ADDR   = 8'h02;
  localparam logic [8:0]  FRAME_MIN_HDR  = 9'd8;
  localparam logic [8:0]  FRAME_MIN_PDU  = 9'd12;
  localparam logic [15:0] MAX_READ       = 16'd125;
  localparam logic [15:0] EXC_LENGTH     = 16'd3;
  localparam int          CNT_W          = 7;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_EXC   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CLS_DROP   = 2'd0,
    CLS_SINGLE = 2'd1,
    CLS_READ   = 2'd2
  } cls_t;

  typedef struct packed {
    logic [8:0]  frame_length;
    logic [15:0] trans_id;
    logic [15:0] protocol_id;
    logic [15:0] length_field;
    logic [7:0]  unit_id;
    logic [7:0]  func;
    logic [15:0] word_a;
    logic [15:0] word_b;
  } req_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [15:0] out_transaction;
    logic [15:0] out_protocol;
    logic [15:0] out_length;
    logic [7:0]  out_unit;
    logic [7:0]  out_func;
    logic [7:0]  out_info;
    logic [15:0] out_word;
    logic [15:0] out_word2;
    logic        word_valid;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic load;
    logic fetch;
    logic advance;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic last;
    logic req_valid;
    logic rsp_ready;
  } sts_t;

endpackage

@@ sv/mbs_req_if.sv @@
// request channel: one pre-split modbus tcp frame per beat
interface mbs_req_if;
  logic        valid;
  logic        ready;
  logic [8:0]  frame_length;
  logic [15:0] trans_id;
  logic [15:0] protocol_id;
  logic [15:0] length_field;
  logic [7:0]  unit_id;
  logic [7:0]  func;
  logic [15:0] word_a;
  logic [15:0] word_b;

  modport source (
    output valid, frame_length, trans_id, protocol_id, length_field,
    output unit_id, func, word_a, word_b,
    input  ready
  );
  modport sink (
    input  valid, frame_length, trans_id, protocol_id, length_field,
    input  unit_id, func, word_a, word_b,
    output ready
  );
endinterface

@@ sv/mbs_rsp_if.sv @@
// response channel: one result beat per register or per reply
interface mbs_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [15:0] out_transaction;
  logic [15:0] out_protocol;
  logic [15:0] out_length;
  logic [7:0]  out_unit;
  logic [7:0]  out_func;
  logic [7:0]  out_info;
  logic [15:0] out_word;
  logic [15:0] out_word2;
  logic        word_valid;
  logic        last;

  modport source (
    output valid, out_kind, out_transaction, out_protocol, out_length,
    output out_unit, out_func, out_info, out_word, out_word2, word_valid, last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_transaction, out_protocol, out_length,
    input  out_unit, out_func, out_info, out_word, out_word2, word_valid, last,
    output ready
  );
endinterface

@@ sv/mbs_ctrl.sv @@
// request sequencer state machine
module mbs_ctrl
  import mbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DEC   = 4'b0010,
    S_FETCH = 4'b0100,
    S_SEND  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.load = 1'b1;
        case (sts.cls)
          CLS_DROP: state_next = S_IDLE;
          CLS_READ: state_next = S_FETCH;
          default:  state_next = S_SEND;
        endcase
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        cmd.out_valid = 1'b1;
        if (sts.rsp_ready) begin
          if (sts.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/mbs_dp.sv @@
// request registers, holding register store and result registers
module mbs_dp
  import mbs_pkg::*;
#(
  parameter int REGISTER_COUNT = 64
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req_d,
  output cls_t cls,
  output rsp_t rsp_d
);

  localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  req_t r;

  logic [15:0] mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld;
  logic [15:0] mem_q;
  logic        vld_q;

  logic [AW-1:0]    idx;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wa_idx;
  logic [CNT_W-1:0] cnt;
  logic             rd_en;
  logic             wr_en;

  logic short_frame, is_rd, is_wr, rd_bad, wr_bad;

  kind_t       kind;
  logic [15:0] protocol;
  logic [15:0] length;
  logic [7:0]  func_o;
  logic [7:0]  info;
  logic [15:0] word;
  logic [15:0] word2;
  logic        word_valid;
  logic        last;
  logic        sel_mem;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r <= req_d;
    end
  end

  // classify the captured request
  always_comb begin
    short_frame = r.frame_length < FRAME_MIN_HDR;
    is_rd       = r.func == FUNC_READ;
    is_wr       = r.func == FUNC_WRITE;
    rd_bad      = (({1'b0, r.word_a} + {1'b0, r.word_b}) > 17'(REGISTER_COUNT)) ||
                  (r.word_b > MAX_READ);
    wr_bad      = r.word_a >= 16'(REGISTER_COUNT);
    cls         = CLS_SINGLE;
    if (short_frame || ((is_rd || is_wr) && r.frame_length < FRAME_MIN_PDU)) begin
      cls = CLS_DROP;
    end else if (is_rd && !rd_bad && r.word_b != 16'd0) begin
      cls = CLS_READ;
    end
  end

  assign wa_idx  = r.word_a[AW-1:0];
  assign wr_en   = cmd.load && (cls != CLS_DROP) && is_wr && !wr_bad;
  assign rd_en   = cmd.fetch || cmd.advance;
  assign rd_addr = cmd.advance ? idx + AW'(1) : idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa_idx] <= r.word_b;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      vld_q <= vld[rd_addr];
    end
  end

  // written-since-reset flags, unwritten registers read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wa_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind       <= KIND_EXC;
      protocol   <= 16'd0;
      length     <= EXC_LENGTH;
      func_o     <= r.func | FUNC_EXC_FLAG;
      info       <= EXC_ILLEGAL_FN;
      word       <= 16'd0;
      word2      <= 16'd0;
      word_valid <= 1'b0;
      last       <= 1'b1;
      sel_mem    <= 1'b0;
      idx        <= wa_idx;
      cnt        <= r.word_b[CNT_W-1:0];
      if (is_rd) begin
        if (rd_bad) begin
          info <= EXC_BAD_ADDR;
        end else if (r.word_b == 16'd0) begin
          kind   <= KIND_READ;
          func_o <= r.func;
          info   <= 8'd0;
        end else begin
          kind       <= KIND_READ;
          func_o     <= r.func;
          length     <= EXC_LENGTH + {r.word_b[14:0], 1'b0};
          info       <= {r.word_b[6:0], 1'b0};
          word_valid <= 1'b1;
          last       <= r.word_b == 16'd1;
          sel_mem    <= 1'b1;
        end
      end else if (is_wr) begin
        if (wr_bad) begin
          info <= EXC_BAD_ADDR;
        end else begin
          kind       <= KIND_WRITE;
          protocol   <= r.protocol_id;
          length     <= r.length_field;
          func_o     <= r.func;
          info       <= 8'd0;
          word       <= r.word_a;
          word2      <= r.word_b;
          word_valid <= 1'b1;
        end
      end
    end else if (cmd.advance) begin
      idx  <= rd_addr;
      cnt  <= cnt - CNT_W'(1);
      last <= cnt == CNT_W'(2);
    end
  end

  always_comb begin
    rsp_d.out_kind        = kind;
    rsp_d.out_transaction = r.trans_id;
    rsp_d.out_protocol    = protocol;
    rsp_d.out_length      = length;
    rsp_d.out_unit        = r.unit_id;
    rsp_d.out_func        = func_o;
    rsp_d.out_info        = info;
    rsp_d.out_word        = sel_mem ? (vld_q ? mem_q : 16'd0) : word;
    rsp_d.out_word2       = word2;
    rsp_d.word_valid      = word_valid;
    rsp_d.last            = last;
  end

endmodule

@@ sv/modbus_tcp_register_server_core.sv @@
// top level of the modbus tcp holding register server
// result path: request captured in idle, then decode, then fetch for a read with data, then send
// reads stream one register beat per cycle while the sink holds ready, from the store's registered read port
// a read sends one beat per requested register; a write, exception or zero-count read one beat; a dropped frame none
// one request in flight; ready is high only between requests
// reset: synchronous; store reads as zero through per-register written flags, no clear pass
module modbus_tcp_register_server_core
  import mbs_pkg::*;
#(
  parameter int REGISTER_COUNT = 64
) (
  input logic      clk,
  input logic      rst,
  mbs_req_if.sink  req,
  mbs_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;
  req_t req_d;
  rsp_t rsp_d;
  cls_t cls;

  always_comb begin
    req_d.frame_length = req.frame_length;
    req_d.trans_id     = req.trans_id;
    req_d.protocol_id  = req.protocol_id;
    req_d.length_field = req.length_field;
    req_d.unit_id      = req.unit_id;
    req_d.func         = req.func;
    req_d.word_a       = req.word_a;
    req_d.word_b       = req.word_b;
  end

  always_comb begin
    sts.cls       = cls;
    sts.last      = rsp_d.last;
    sts.req_valid = req.valid;
    sts.rsp_ready = rsp.ready;
  end

  mbs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  mbs_dp #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .req_d (req_d),
    .cls   (cls),
    .rsp_d (rsp_d)
  );

  assign req.ready           = cmd.in_ready;
  assign rsp.valid           = cmd.out_valid;
  assign rsp.out_kind        = rsp_d.out_kind;
  assign rsp.out_transaction = rsp_d.out_transaction;
  assign rsp.out_protocol    = rsp_d.out_protocol;
  assign rsp.out_length      = rsp_d.out_length;
  assign rsp.out_unit        = rsp_d.out_unit;
  assign rsp.out_func        = rsp_d.out_func;
  assign rsp.out_info        = rsp_d.out_info;
  assign rsp.out_word        = rsp_d.out_word;
  assign rsp.out_word2       = rsp_d.out_word2;
  assign rsp.word_valid      = rsp_d.word_valid;
  assign rsp.last            = rsp_d.last;

endmodule

@@ sv/mbs_chk.sv @@
// port-level checks for the modbus tcp register server and their binding
module mbs_chk
  import mbs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_kind,
  input logic       rsp_word_valid,
  input logic       rsp_last
);

  // one request in flight at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while a result beat is pending");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("ready stayed high after a request beat");

  a_exc_single: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_kind == KIND_EXC) |-> (rsp_last && !rsp_word_valid))
    else $error("exception beat not a lone final beat");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && rsp_last) |=> !rsp_valid)
    else $error("result beat after the final beat");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result beat withdrawn before it was taken");

endmodule

bind modbus_tcp_register_server_core mbs_chk u_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_kind       (rsp.out_kind),
  .rsp_word_valid (rsp.word_valid),
  .rsp_last       (rsp.last)
);
